### rtl/spa_pkg.sv
// Shared types, codes and constants for the segment pool allocator.
// Used by every rtl file of the block; depends on nothing.
package spa_pkg;

    localparam int unsigned POOL_BYTES_DEF   = 1024 * 1024 * 32;
    localparam int unsigned MAX_SEGMENTS_DEF = 256;

    typedef enum logic [1:0] {
        CMD_FIRST_FIT = 2'd0,
        CMD_SMALL_FIT = 2'd1,
        CMD_RELEASE   = 2'd2,
        CMD_COALESCE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // one table entry; arithmetic on start/size wraps at 32 bits
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        used;
        logic        mark;
    } seg_entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [24:0] granted;
        logic [25:0] free_bytes;
        logic [8:0]  seg_total;
        logic [8:0]  free_seg_total;
    } spa_result_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_AL_RD,
        S_AL_EV,
        S_AL_WR_PICK,
        S_AL_WR_REM,
        S_RL_RD,
        S_RL_EV,
        S_CI_RD,
        S_CI_EV,
        S_CH_RD,
        S_CH_EV,
        S_CA_RD,
        S_CA_EV,
        S_CP_RD,
        S_CP_EV,
        S_DONE
    } spa_state_t;

endpackage

### rtl/spa_table.sv
// Segment table memory: one write port, one read port, registered read data.
// Depends on spa_pkg for the entry type.
module spa_table
    import spa_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_SEGMENTS_DEF,
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  seg_entry_t       wdata,
    input  logic [IDX_W-1:0] raddr,
    output seg_entry_t       rdata
);

    seg_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/spa_ctrl.sv
// Command sequencer: walks the segment table one entry per read for every
// command; compares and adds are combinational. Depends on spa_pkg, spa_table port.
module spa_ctrl
    import spa_pkg::*;
#(
    parameter int unsigned POOL_BYTES   = POOL_BYTES_DEF,
    parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       command,
    input  logic [25:0]      request_size,
    input  logic [24:0]      release_offset,
    output logic             idle,
    input  logic             load_ok,
    output logic             done,
    output spa_result_t      result,
    output logic             we,
    output logic [IDX_W-1:0] waddr,
    output seg_entry_t       wdata,
    output logic [IDX_W-1:0] raddr,
    input  seg_entry_t       rdata
);

    spa_state_t        state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [31:0]       req_reg, req_next;
    logic [31:0]       off_reg, off_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [31:0]       free_reg, free_next;
    logic [31:0]       cur_start_reg, cur_start_next;
    logic [31:0]       cur_size_reg, cur_size_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_idx_reg, pick_idx_next;
    logic [31:0]       pick_start_reg, pick_start_next;
    logic [31:0]       pick_size_reg, pick_size_next;
    logic [1:0]        status_reg, status_next;
    logic [24:0]       granted_reg, granted_next;

    logic [31:0]       cur_end;
    logic [31:0]       cnt32;
    logic [31:0]       fcnt32;

    assign cur_end = cur_start_reg + cur_size_reg;
    assign cnt32   = 32'(cnt_reg);
    assign fcnt32  = 32'(fcnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= CNT_W'(1);
            fcnt_reg  <= CNT_W'(1);
            free_reg  <= 32'(POOL_BYTES);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fcnt_reg  <= fcnt_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        req_reg        <= req_next;
        off_reg        <= off_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        n_reg          <= n_next;
        cur_start_reg  <= cur_start_next;
        cur_size_reg   <= cur_size_next;
        found_reg      <= found_next;
        pick_idx_reg   <= pick_idx_next;
        pick_start_reg <= pick_start_next;
        pick_size_reg  <= pick_size_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        req_next        = req_reg;
        off_next        = off_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        fcnt_next       = fcnt_reg;
        free_next       = free_reg;
        cur_start_next  = cur_start_reg;
        cur_size_next   = cur_size_reg;
        found_next      = found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_start_next = pick_start_reg;
        pick_size_next  = pick_size_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        idle            = 1'b0;
        done            = 1'b0;
        we              = 1'b0;
        waddr           = j_reg[IDX_W-1:0];
        wdata           = rdata;
        raddr           = j_reg[IDX_W-1:0];

        case (state_reg)
            S_INIT:
            begin
                we          = 1'b1;
                waddr       = '0;
                wdata.start = '0;
                wdata.size  = 32'(POOL_BYTES);
                wdata.used  = 1'b0;
                wdata.mark  = 1'b0;
                state_next  = S_IDLE;
            end
            S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    cmd_next     = command;
                    req_next     = 32'(request_size);
                    off_next     = 32'(release_offset);
                    j_next       = '0;
                    i_next       = '0;
                    found_next   = 1'b0;
                    status_next  = ST_OK;
                    granted_next = '0;
                    case (command)
                        CMD_FIRST_FIT, CMD_SMALL_FIT:
                        begin
                            if (cnt_reg >= CNT_W'(MAX_SEGMENTS))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_AL_RD;
                            end
                        end
                        CMD_RELEASE:   state_next = S_RL_RD;
                        default:       state_next = S_CI_RD;
                    endcase
                end
            end
            S_AL_RD:
            begin
                if (j_reg == cnt_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = S_AL_WR_PICK;
                    end
                    else
                    begin
                        status_next = ST_NO_FIT;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_AL_EV;
                end
            end
            S_AL_EV:
            begin
                j_next     = j_reg + 1'b1;
                state_next = S_AL_RD;
                if (!rdata.used && rdata.size >= req_reg &&
                    (!found_reg || rdata.size < pick_size_reg))
                begin
                    found_next      = 1'b1;
                    pick_idx_next   = j_reg[IDX_W-1:0];
                    pick_start_next = rdata.start;
                    pick_size_next  = rdata.size;
                    if (cmd_reg == CMD_FIRST_FIT)
                    begin
                        state_next = S_AL_WR_PICK;
                    end
                end
            end
            S_AL_WR_PICK:
            begin
                we           = 1'b1;
                waddr        = pick_idx_reg;
                wdata.start  = pick_start_reg;
                wdata.size   = req_reg;
                wdata.used   = 1'b1;
                wdata.mark   = 1'b0;
                granted_next = pick_start_reg[24:0];
                free_next    = free_reg - req_reg;
                if (pick_size_reg != req_reg)
                begin
                    state_next = S_AL_WR_REM;
                end
                else
                begin
                    fcnt_next  = fcnt_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_AL_WR_REM:
            begin
                we          = 1'b1;
                waddr       = cnt_reg[IDX_W-1:0];
                wdata.start = pick_start_reg + req_reg;
                wdata.size  = pick_size_reg - req_reg;
                wdata.used  = 1'b0;
                wdata.mark  = 1'b0;
                cnt_next    = cnt_reg + 1'b1;
                state_next  = S_DONE;
            end
            S_RL_RD:
            begin
                if (j_reg == cnt_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_RL_EV;
                end
            end
            S_RL_EV:
            begin
                if (rdata.start == off_reg)
                begin
                    if (rdata.used)
                    begin
                        we         = 1'b1;
                        wdata.used = 1'b0;
                        free_next  = free_reg + rdata.size;
                        fcnt_next  = fcnt_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RL_RD;
                end
            end
            // coalesce: pick a candidate head i
            S_CI_RD:
            begin
                raddr = i_reg[IDX_W-1:0];
                if (i_reg == cnt_reg)
                begin
                    i_next     = '0;
                    n_next     = '0;
                    fcnt_next  = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    state_next = S_CI_EV;
                end
            end
            S_CI_EV:
            begin
                cur_start_next = rdata.start;
                cur_size_next  = rdata.size;
                j_next         = '0;
                if (rdata.used || rdata.mark)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CI_RD;
                end
                else
                begin
                    state_next = S_CH_RD;
                end
            end
            // head check: no other free entry ends where i starts
            S_CH_RD:
            begin
                if (j_reg == cnt_reg)
                begin
                    j_next     = '0;
                    state_next = S_CA_RD;
                end
                else
                begin
                    state_next = S_CH_EV;
                end
            end
            S_CH_EV:
            begin
                if (j_reg != i_reg && !rdata.used &&
                    (rdata.start + rdata.size) == cur_start_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CI_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_CH_RD;
                end
            end
            // absorb: first unmarked free entry starting at the current end
            S_CA_RD:
            begin
                if (j_reg == cnt_reg)
                begin
                    we          = 1'b1;
                    waddr       = i_reg[IDX_W-1:0];
                    wdata.start = cur_start_reg;
                    wdata.size  = cur_size_reg;
                    wdata.used  = 1'b0;
                    wdata.mark  = 1'b0;
                    i_next      = i_reg + 1'b1;
                    state_next  = S_CI_RD;
                end
                else
                begin
                    state_next = S_CA_EV;
                end
            end
            S_CA_EV:
            begin
                state_next = S_CA_RD;
                if (j_reg != i_reg && !rdata.mark && !rdata.used &&
                    rdata.start == cur_end)
                begin
                    we            = 1'b1;
                    wdata.mark    = 1'b1;
                    cur_size_next = cur_size_reg + rdata.size;
                    j_next        = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            // compaction: drop marked entries, keep order
            S_CP_RD:
            begin
                raddr = i_reg[IDX_W-1:0];
                if (i_reg == cnt_reg)
                begin
                    cnt_next   = n_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CP_EV;
                end
            end
            S_CP_EV:
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_CP_RD;
                if (!rdata.mark)
                begin
                    we     = 1'b1;
                    waddr  = n_reg[IDX_W-1:0];
                    n_next = n_reg + 1'b1;
                    if (!rdata.used)
                    begin
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (load_ok)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.status         = status_reg;
    assign result.granted        = granted_reg;
    assign result.free_bytes     = free_reg[25:0];
    assign result.seg_total      = cnt32[8:0];
    assign result.free_seg_total = fcnt32[8:0];

endmodule

### rtl/segment_pool_allocator.sv
// Segment pool allocator: keeps a table of pool segments (start, size, used)
// and serves first-fit / smallest-fit allocation, release and coalesce.
//
// Channels: input requests (command, request_size, release_offset) on
// in_valid/in_stall; one result per request on out_valid/out_stall.
// A request is taken only while the sequencer is idle; in_stall is high
// while one is being worked on.
// Each table read goes through a read state and an evaluate state.
// Allocation and release scan the table; coalesce runs a head check scan per
// free entry, restarts a table scan for each absorbed entry, and ends with
// a compaction pass. The single read port of the segment table sets the
// pace of all these scans.
// After reset the S_INIT state writes the whole-pool entry before the first request
// is taken. Results sit in an output register; a new request may be taken
// while a result waits, but its own result is held in the sequencer until
// the output register frees up, so nothing is lost under out_stall.
// total_bytes is the pool size, which every command preserves.
module segment_pool_allocator
    import spa_pkg::*;
#(
    parameter int unsigned POOL_BYTES   = POOL_BYTES_DEF,
    parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [25:0] request_size,
    input  logic [24:0] release_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [24:0] granted_offset,
    output logic [25:0] total_bytes,
    output logic [25:0] free_bytes,
    output logic [8:0]  segment_total,
    output logic [8:0]  free_segment_total
);

    localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam logic [31:0] POOL32 = 32'(POOL_BYTES);

    logic             idle;
    logic             done;
    logic             load_ok;
    spa_result_t      result;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    seg_entry_t       wdata;
    seg_entry_t       rdata;

    logic             out_valid_reg, out_valid_next;
    spa_result_t      out_data_reg, out_data_next;

    assign in_stall = !idle;
    assign load_ok  = !out_valid_reg || !out_stall;

    spa_table #(
        .DEPTH(MAX_SEGMENTS)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    spa_ctrl #(
        .POOL_BYTES  (POOL_BYTES),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_valid),
        .command       (command),
        .request_size  (request_size),
        .release_offset(release_offset),
        .idle          (idle),
        .load_ok       (load_ok),
        .done          (done),
        .result        (result),
        .we            (we),
        .waddr         (waddr),
        .wdata         (wdata),
        .raddr         (raddr),
        .rdata         (rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_data_reg.status;
    assign granted_offset     = out_data_reg.granted;
    assign total_bytes        = POOL32[25:0];
    assign free_bytes         = out_data_reg.free_bytes;
    assign segment_total      = out_data_reg.seg_total;
    assign free_segment_total = out_data_reg.free_seg_total;

endmodule

### rtl/spa_checker.sv
// Port-level checks for segment_pool_allocator, bound to the top level.
// Depends on spa_pkg for the status codes.
module spa_checker
    import spa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [24:0] granted_offset,
    input logic [25:0] free_bytes,
    input logic [8:0]  segment_total,
    input logic [8:0]  free_segment_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) &&
        $stable(granted_offset) && $stable(free_bytes))
        else $error("result changed while stalled");

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_offset == 25'd0)
        else $error("granted offset set on a failed request");

    a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> free_segment_total <= segment_total)
        else $error("more free segments than segments");

    a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> segment_total != 9'd0 || free_segment_total == 9'd0)
        else $error("free segments reported with empty table");

endmodule

bind segment_pool_allocator spa_checker u_spa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .granted_offset    (granted_offset),
    .free_bytes        (free_bytes),
    .segment_total     (segment_total),
    .free_segment_total(free_segment_total)
);

### verif/segment_pool_allocator_test.sv
// Self-checking testbench for segment_pool_allocator: predicts each result from
// its own copy of the segment table and checks every result in order.
// Depends on rtl/spa_pkg.sv and rtl/segment_pool_allocator.sv.
`timescale 1ns / 1ps

module segment_pool_allocator_test;
    import spa_pkg::*;

    localparam int unsigned POOL  = POOL_BYTES_DEF;
    localparam int unsigned SEGS  = MAX_SEGMENTS_DEF;
    localparam int unsigned LIMIT = 6000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [24:0] granted;
        logic [25:0] total;
        logic [25:0] free_b;
        logic [8:0]  seg_n;
        logic [8:0]  free_n;
    } spa_outcome_t;

    class pool_scoreboard;
        logic [31:0] seg_start [SEGS];
        logic [31:0] seg_size [SEGS];
        bit          seg_used [SEGS];
        bit          absorbed [SEGS];
        int unsigned seg_n;
        int unsigned free_b;
        int unsigned free_n;
        spa_outcome_t pending[$];
        int unsigned errors;

        function void clear_table();
            seg_start[0] = 0;
            seg_size[0] = POOL;
            seg_used[0] = 0;
            seg_n = 1;
            free_b = POOL;
            free_n = 1;
            errors = 0;
        endfunction

        function logic [31:0] seg_end(int unsigned k);
            return seg_start[k] + seg_size[k];
        endfunction

        function bit run_head(int unsigned i);
            for (int unsigned j = 0; j < seg_n; j++)
                if (j != i && !seg_used[j] && seg_end(j) == seg_start[i])
                    return 0;
            return 1;
        endfunction

        function void merge_free();
            int unsigned n;
            bit grew;
            n = 0;
            for (int unsigned i = 0; i < SEGS; i++) absorbed[i] = 0;
            for (int unsigned i = 0; i < seg_n; i++)
            begin
                if (seg_used[i] || absorbed[i] || !run_head(i)) continue;
                grew = 1;
                while (grew)
                begin
                    grew = 0;
                    for (int unsigned j = 0; j < seg_n; j++)
                    begin
                        if (j != i && !absorbed[j] && !seg_used[j] &&
                            seg_start[j] == seg_end(i))
                        begin
                            absorbed[j] = 1;
                            seg_size[i] += seg_size[j];
                            grew = 1;
                            break;
                        end
                    end
                end
            end
            free_n = 0;
            for (int unsigned i = 0; i < seg_n; i++)
            begin
                if (absorbed[i]) continue;
                seg_start[n] = seg_start[i];
                seg_size[n] = seg_size[i];
                seg_used[n] = seg_used[i];
                if (!seg_used[n]) free_n++;
                n++;
            end
            seg_n = n;
        endfunction

        function logic [1:0] grant(logic [31:0] req, bit smallest, output logic [31:0] off);
            bit found;
            int unsigned pick;
            found = 0;
            pick = 0;
            off = 0;
            if (seg_n >= SEGS) return ST_FULL;
            for (int unsigned i = 0; i < seg_n; i++)
            begin
                if (seg_used[i] || seg_size[i] < req) continue;
                if (!found)
                begin
                    found = 1;
                    pick = i;
                    if (!smallest) break;
                end
                else if (seg_size[i] < seg_size[pick])
                    pick = i;
            end
            if (!found) return ST_NO_FIT;
            if (seg_size[pick] != req)
            begin
                seg_used[seg_n] = 0;
                seg_size[seg_n] = seg_size[pick] - req;
                seg_start[seg_n] = seg_start[pick] + req;
                seg_n++;
            end
            else
                free_n--;
            free_b -= req;
            seg_used[pick] = 1;
            seg_size[pick] = req;
            off = seg_start[pick];
            return ST_OK;
        endfunction

        function logic [1:0] free_at(logic [31:0] off);
            for (int unsigned i = 0; i < seg_n; i++)
            begin
                if (seg_start[i] == off)
                begin
                    if (seg_used[i])
                    begin
                        seg_used[i] = 0;
                        free_b += seg_size[i];
                        free_n++;
                    end
                    return ST_OK;
                end
            end
            return ST_NOT_FOUND;
        endfunction

        function void note_request(cmd_t cmd, logic [25:0] req, logic [24:0] off);
            spa_outcome_t o;
            logic [31:0] g;
            logic [31:0] sum;
            g = 0;
            o.status = ST_OK;
            if (cmd == CMD_FIRST_FIT || cmd == CMD_SMALL_FIT)
            begin
                o.status = grant({6'd0, req}, cmd == CMD_SMALL_FIT, g);
                if (o.status != ST_OK) g = 0;
            end
            else if (cmd == CMD_RELEASE)
                o.status = free_at({7'd0, off});
            else
                merge_free();
            sum = 0;
            for (int unsigned i = 0; i < seg_n; i++) sum += seg_size[i];
            o.granted = g[24:0];
            o.total = sum[25:0];
            o.free_b = free_b[25:0];
            o.seg_n = seg_n[8:0];
            o.free_n = free_n[8:0];
            pending.push_back(o);
        endfunction

        function void check_result(spa_outcome_t got);
            spa_outcome_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result, status %0d", got.status);
                return;
            end
            e = pending.pop_front();
            if (got != e)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: exp st=%0d off=%0h tot=%0h free=%0h seg=%0d fseg=%0d",
                        e.status, e.granted, e.total, e.free_b, e.seg_n, e.free_n);
                    $display("          got st=%0d off=%0h tot=%0h free=%0h seg=%0d fseg=%0d",
                        got.status, got.granted, got.total, got.free_b, got.seg_n,
                        got.free_n);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [25:0] request_size;
    logic [24:0] release_offset;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [24:0] granted_offset;
    logic [25:0] total_bytes;
    logic [25:0] free_bytes;
    logic [8:0]  segment_total;
    logic [8:0]  free_segment_total;

    pool_scoreboard sb;
    bit quiet;
    bit hold_req;
    int unsigned cycles;

    segment_pool_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .request_size(request_size), .release_offset(release_offset),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .granted_offset(granted_offset), .total_bytes(total_bytes),
        .free_bytes(free_bytes), .segment_total(segment_total),
        .free_segment_total(free_segment_total)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("segment_pool_allocator verification failed");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1;
                repeat (3000) @(negedge clk);
                hold_req = 0;
                out_stall = 0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
                out_stall = 0;
        end
    end

    always @(posedge clk)
    begin
        spa_outcome_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status;
            got.granted = granted_offset;
            got.total = total_bytes;
            got.free_b = free_bytes;
            got.seg_n = segment_total;
            got.free_n = free_segment_total;
            sb.check_result(got);
        end
    end

    task automatic send_request(cmd_t cmd, logic [25:0] req, logic [24:0] off);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid = 1;
        command = cmd;
        request_size = req;
        release_offset = off;
        do @(posedge clk); while (in_stall);
        sb.note_request(cmd, req, off);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // pick a segment start: prefer used ones when asked (up to eight tries), else any
    function automatic logic [24:0] some_start(bit want_used);
        int unsigned k;
        for (int t = 0; t < 8; t++)
        begin
            k = $urandom_range(0, sb.seg_n - 1);
            if (!want_used || sb.seg_used[k]) return sb.seg_start[k][24:0];
        end
        return sb.seg_start[k][24:0];
    endfunction

    task automatic random_request();
        int unsigned r;
        int unsigned used_n;
        logic [25:0] req;
        used_n = sb.seg_n - sb.free_n;
        r = $urandom_range(0, 99);
        if (sb.seg_n > 16 || used_n > 8)
        begin
            if (r < 40) send_request(CMD_COALESCE, 26'($urandom), 25'($urandom));
            else send_request(CMD_RELEASE, 26'($urandom), some_start(1));
            return;
        end
        case ($urandom_range(0, 9))
            0: req = 26'($urandom);
            1: req = 0;
            2: req = sb.seg_size[$urandom_range(0, sb.seg_n - 1)][25:0];
            3: req = 26'($urandom_range(1, 64));
            default: req = 26'($urandom_range(1, 1 << 22));
        endcase
        if (r < 30) send_request(CMD_FIRST_FIT, req, 25'($urandom));
        else if (r < 55) send_request(CMD_SMALL_FIT, req, 25'($urandom));
        else if (r < 77) send_request(CMD_RELEASE, 26'($urandom), some_start(1));
        else if (r < 85) send_request(CMD_RELEASE, 26'($urandom), 25'($urandom));
        else send_request(CMD_COALESCE, 26'($urandom), 25'($urandom));
    endtask

    initial
    begin
        logic [24:0] starts[$];
        int unsigned waited;
        sb = new();
        sb.clear_table();
        quiet = 0;
        hold_req = 0;
        cycles = 0;
        rst_n = 0;
        in_valid = 0;
        command = CMD_FIRST_FIT;
        request_size = 0;
        release_offset = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: zero-size, no fit, unknown offset, double release, exact fit
        send_request(CMD_FIRST_FIT, 0, 0);
        send_request(CMD_SMALL_FIT, 0, 0);
        send_request(CMD_FIRST_FIT, 26'(POOL + 1), 0);
        send_request(CMD_SMALL_FIT, 26'h3FFFFFF, 0);
        send_request(CMD_RELEASE, 0, 25'h1FFFFFF);
        send_request(CMD_RELEASE, 0, 0);
        send_request(CMD_RELEASE, 0, 0);
        send_request(CMD_COALESCE, 0, 0);
        send_request(CMD_FIRST_FIT, 100, 0);
        send_request(CMD_FIRST_FIT, 300, 0);
        send_request(CMD_FIRST_FIT, 50, 0);
        send_request(CMD_RELEASE, 0, 0);
        send_request(CMD_RELEASE, 0, 400);
        send_request(CMD_SMALL_FIT, 40, 0);
        send_request(CMD_RELEASE, 0, 100);
        send_request(CMD_COALESCE, 0, 0);
        send_request(CMD_RELEASE, 0, 0);
        send_request(CMD_RELEASE, 0, 40);
        send_request(CMD_COALESCE, 0, 0);
        send_request(CMD_FIRST_FIT, 26'(POOL), 0);
        send_request(CMD_FIRST_FIT, 1, 0);
        send_request(CMD_RELEASE, 0, 0);
        send_request(CMD_SMALL_FIT, 26'(POOL), 0);
        send_request(CMD_RELEASE, 0, 0);

        // fill the table to its limit, then empty and merge it
        while (sb.seg_n < SEGS) send_request(CMD_FIRST_FIT, 1, 0);
        send_request(CMD_FIRST_FIT, 1, 0);
        send_request(CMD_SMALL_FIT, 0, 0);
        send_request(CMD_COALESCE, 0, 0);
        for (int unsigned i = 0; i < sb.seg_n; i++)
            if (sb.seg_used[i]) starts.push_back(sb.seg_start[i][24:0]);
        foreach (starts[i]) send_request(CMD_RELEASE, 0, starts[i]);
        send_request(CMD_COALESCE, 0, 0);
        send_request(CMD_COALESCE, 0, 0);

        for (int n = 0; n < 210; n++)
        begin
            if (n == 50) hold_req = 1;
            if (n == 100) drain_results();
            if (n == 170) quiet = 1;
            random_request();
        end

        @(negedge clk);
        in_valid = 0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 2000000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2000) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("segment_pool_allocator verification clean");
        else
            $display("segment_pool_allocator verification failed");
        $finish;
    end

endmodule

### segment_pool_allocator.f
rtl/spa_pkg.sv
rtl/spa_table.sv
rtl/spa_ctrl.sv
rtl/segment_pool_allocator.sv
rtl/spa_checker.sv
verif/segment_pool_allocator_test.sv
